// ----- sv/wbps_pkg.sv -----
`default_nettype none

package wbps_pkg;

  // Window depth and width of the saturating byte count.
  localparam int PATTERN_MAX  = 16;
  localparam int OFFSET_WIDTH = 32;

  // Field widths fixed by the register map and the channels.
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int WILDCARD_W  = 16;
  localparam int LENGTH_W    = 5;
  localparam int CFG_INDEX_W = 3;

  // Width of a pattern position and of an effective length (1 to PATTERN_MAX).
  localparam int POS_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN   = 3'd4;

  // Control handed from the top level to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/wbps_in_if.sv -----
`default_nettype none

interface wbps_in_if;
  logic                           valid;
  logic                           ready;
  logic [wbps_pkg::BYTE_W-1:0]    data_byte;
  logic                           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/wbps_out_if.sv -----
`default_nettype none

interface wbps_out_if;
  logic                           valid;
  logic                           ready;
  logic                           match_found;
  logic [wbps_pkg::ADDR_W-1:0]    match_address;
  logic                           end_of_scan;

  modport source (output valid, output match_found, output match_address,
                  output end_of_scan, input ready);
  modport sink   (input valid, input match_found, input match_address,
                  input end_of_scan, output ready);
endinterface

`default_nettype wire

// ----- sv/wbps_cell.sv -----
`default_nettype none

// One window position: holds a byte, passes it on at each shift and records
// whether the byte it takes in agrees with the pattern byte aimed at it.
module wbps_cell (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  wbps_pkg::cell_ctrl_t       ctrl,
  input  wire  [wbps_pkg::BYTE_W-1:0]      byte_in,
  input  wire  [wbps_pkg::BYTE_W-1:0]      pattern_byte,
  input  wire                              care,
  output logic [wbps_pkg::BYTE_W-1:0]      byte_out,
  output logic                             hit
);

  logic [wbps_pkg::BYTE_W-1:0] window_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_byte <= '0;
    end else if (ctrl.shift) begin
      window_byte <= ctrl.clear ? '0 : byte_in;
    end
  end

  // The compare looks at the byte as it enters, so it belongs to the same
  // window as the shift that stores it.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hit <= !care || (byte_in == pattern_byte);
    end
  end

  assign byte_out = window_byte;

endmodule

`default_nettype wire

// ----- sv/wildcard_byte_pattern_scan.sv -----
// Byte signature scanner with wildcards.
// The input channel carries one byte of a memory image per transaction, with
// last_byte marking the final byte. The output channel carries at most one
// transaction per input byte: one whenever base_address is not zero and the
// most recent pattern_length bytes match every non-wildcard pattern byte
// (match_address is base_address plus the offset of the first matching byte),
// and one for the last byte in any case, flagged end_of_scan. Configuration
// is written through a plain write port (cfg_we, cfg_index, cfg_data) while
// the block is idle, a rule for the user that the block does not enforce.
// Throughput is one byte per cycle unless a held result blocks stage one: the
// window is a chain of sixteen cells that shift and compare in the cycle a
// byte is taken. The output register after stage one combines the cell hits
// and adds the start offset to the base address. If the receiver stalls, the
// result waits there while stage one takes bytes until it holds one with a
// result; a byte that gives no result never holds up the input. Reset clears
// the window, the count and both pipeline stages and returns the registers
// to their reset values (pattern length one, everything else zero). After
// the last byte of an image the window and the count return to zero as well.
`default_nettype none

module wildcard_byte_pattern_scan (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [wbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [wbps_pkg::CFG_DATA_W-1:0]       cfg_data,
  wbps_in_if.sink                               in_ch,
  wbps_out_if.source                            out_ch
);

  // Configuration registers.
  logic [wbps_pkg::ADDR_W-1:0]     base_address;
  logic [wbps_pkg::CFG_DATA_W-1:0] pattern_low_bytes;
  logic [wbps_pkg::CFG_DATA_W-1:0] pattern_high_bytes;
  logic [wbps_pkg::WILDCARD_W-1:0] wildcard_mask;
  logic [wbps_pkg::LENGTH_W-1:0]   pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address       <= '0;
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      wildcard_mask      <= '0;
      pattern_length     <= wbps_pkg::LENGTH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_BASE_ADDRESS:  base_address       <= cfg_data;
        wbps_pkg::REG_PATTERN_LOW:   pattern_low_bytes  <= cfg_data;
        wbps_pkg::REG_PATTERN_HIGH:  pattern_high_bytes <= cfg_data;
        wbps_pkg::REG_WILDCARD_MASK: wildcard_mask      <= cfg_data[wbps_pkg::WILDCARD_W-1:0];
        wbps_pkg::REG_PATTERN_LEN:   pattern_length     <= cfg_data[wbps_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // A length of zero counts as one; anything beyond the window is clipped.
  logic [wbps_pkg::LEN_W-1:0] len_eff;

  always_comb begin
    priority if (pattern_length == '0) begin
      len_eff = wbps_pkg::LEN_W'(1);
    end else if (pattern_length > wbps_pkg::LENGTH_W'(wbps_pkg::PATTERN_MAX)) begin
      len_eff = wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX);
    end else begin
      len_eff = wbps_pkg::LEN_W'(pattern_length);
    end
  end

  // Handshake and pipeline control. Stage one is the row of cell hits plus
  // the window-full flag, the start offset and the last-byte flag; stage two
  // is the output register.
  logic                                s1_valid;
  logic                                s1_full;
  logic [wbps_pkg::OFFSET_WIDTH-1:0]   s1_offset;
  logic                                s1_last;
  logic [wbps_pkg::PATTERN_MAX-1:0]    hits;
  logic                                s1_match;
  logic                                s1_result;
  logic                                out_valid;
  logic                                advance;
  logic                                s1_free;
  logic                                accept;

  assign advance   = !out_valid || out_ch.ready;
  assign s1_match  = s1_full && (&hits);
  assign s1_result = s1_match || s1_last;
  // Stage one empties when it is empty, has nothing to deliver, or can move on.
  assign s1_free   = !s1_valid || !s1_result || advance;
  assign accept    = in_ch.valid && s1_free;
  assign in_ch.ready = s1_free;

  // Saturating byte count of the current image.
  logic [wbps_pkg::OFFSET_WIDTH-1:0] bytes_seen;
  logic [wbps_pkg::OFFSET_WIDTH-1:0] bytes_seen_next;
  logic [wbps_pkg::OFFSET_WIDTH-1:0] len_wide;

  assign bytes_seen_next = (bytes_seen == '1) ? bytes_seen
                                              : bytes_seen + wbps_pkg::OFFSET_WIDTH'(1);
  assign len_wide = wbps_pkg::OFFSET_WIDTH'(len_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (accept) begin
      bytes_seen <= in_ch.last_byte ? '0 : bytes_seen_next;
    end
  end

  // Pattern byte and care flag aimed at each cell. Cell j holds the byte that
  // arrived j bytes ago, so it faces pattern position len - 1 - j.
  logic [2*wbps_pkg::CFG_DATA_W-1:0] pattern_all;
  logic [wbps_pkg::BYTE_W-1:0]       cell_pat  [wbps_pkg::PATTERN_MAX];
  logic                              cell_care [wbps_pkg::PATTERN_MAX];

  assign pattern_all = {pattern_high_bytes, pattern_low_bytes};

  always_comb begin
    logic [wbps_pkg::LEN_W-1:0] pos;
    for (int j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin
      pos = len_eff - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
      cell_pat[j]  = pattern_all[{pos[wbps_pkg::POS_W-1:0], 3'b000} +: wbps_pkg::BYTE_W];
      cell_care[j] = (wbps_pkg::LEN_W'(j) < len_eff)
                     && !wildcard_mask[pos[wbps_pkg::POS_W-1:0]];
    end
  end

  // The chain of window cells. Every cell shifts on an accepted byte, and the
  // last byte of an image leaves the window cleared behind it.
  wbps_pkg::cell_ctrl_t         cell_ctrl;
  logic [wbps_pkg::BYTE_W-1:0]  cell_byte [wbps_pkg::PATTERN_MAX];

  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = in_ch.last_byte;

  for (genvar j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin : g_cell
    logic [wbps_pkg::BYTE_W-1:0] cell_in;
    if (j == 0) begin : g_head
      assign cell_in = in_ch.data_byte;
    end else begin : g_link
      assign cell_in = cell_byte[j-1];
    end
    wbps_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cell_ctrl),
      .byte_in      (cell_in),
      .pattern_byte (cell_pat[j]),
      .care         (cell_care[j]),
      .byte_out     (cell_byte[j]),
      .hit          (hits[j])
    );
  end

  // Stage one: the rest of the compare-stage payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_full   <= (base_address != '0) && (bytes_seen_next >= len_wide);
      s1_offset <= bytes_seen_next - len_wide;
      s1_last   <= in_ch.last_byte;
    end
  end

  // Stage two: output register.
  logic                        match_found;
  logic [wbps_pkg::ADDR_W-1:0] match_address;
  logic                        end_of_scan;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_result) begin
      match_found   <= s1_match;
      match_address <= s1_match ? base_address + wbps_pkg::ADDR_W'(s1_offset) : '0;
      end_of_scan   <= s1_last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.match_found   = match_found;
  assign out_ch.match_address = match_address;
  assign out_ch.end_of_scan   = end_of_scan;

`ifndef SYNTHESIS
  // A result without a match can only be the end-of-scan result.
  a_nomatch_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> end_of_scan)
    else $error("result without match and without end of scan");

  // A missed match reports address zero.
  a_nomatch_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> match_address == '0)
    else $error("non-zero address on a result without match");

  // A zero base address never yields a match.
  a_base_gates: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_found |-> base_address != '0)
    else $error("match reported with zero base address");

  // The last byte of an image restarts the count.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.last_byte |=> bytes_seen == '0)
    else $error("byte count not cleared after the last byte");

  // Any other byte leaves a count of at least one.
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    accept && !in_ch.last_byte |=> bytes_seen != '0)
    else $error("byte count zero after a byte was taken");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

// Testbench for the wildcard byte signature scanner.
//
// Input bytes go in through the input channel, and every result transaction
// coming back is checked against a small model of the scanner kept in this
// module. That model holds its own copy of the sliding window, the
// saturating byte count and the five configuration registers.
//
// The run has two parts.
//  * A directed plan, walked row by row. It covers the reset settings (zero
//    base, so nothing matches), the all-ones base with wrap-around of the
//    match address, a pattern length of zero, a wildcard in the middle of a
//    pattern, and writes to unused register indexes. Rows whose result can
//    be read straight off the settings carry it in the table. The other rows
//    are checked against the model.
//  * Random phases. Each phase writes a fresh set of registers while the
//    block is idle, then streams a few images. Much of each image is made of
//    planted copies of the pattern with random bytes at the wildcard
//    positions, so that matches are frequent. Some copies are broken by a
//    flipped bit, and plain noise bytes are mixed in.
//
// Both sides idle in random bursts, except over the final stretch. One phase
// makes every byte match while the receiver holds off for a long time, so
// that the pipeline fills and the input stalls. Every change of settings
// waits until all expected results have come back.
module tb;

  localparam int RANDOM_BYTES  = 1200;
  localparam int CALM_BYTES    = 150;     // final stretch with no idling
  localparam int SETTLE_CYCLES = 4;       // two-stage pipeline, plus margin
  localparam int LONG_HOLD     = 150;
  localparam int HOLD_PHASE    = 4;
  localparam int LIMIT_CYCLES  = 400000;

  // Register indexes beyond the map, whose writes must be ignored.
  localparam logic [wbps_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST =
    wbps_pkg::REG_PATTERN_LEN + 1'b1;
  localparam logic [wbps_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic                        found;
    logic [wbps_pkg::ADDR_W-1:0] addr;
    logic                        eos;
  } scan_result_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t                           kind;
    logic [wbps_pkg::CFG_INDEX_W-1:0]    index;
    logic [wbps_pkg::CFG_DATA_W-1:0]     value;
    logic [wbps_pkg::BYTE_W-1:0]         data;
    logic                                last;
    bit                                  known;      // result typed into the table
    bit                                  known_has;
    scan_result_t                        known_res;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data;

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  wildcard_byte_pattern_scan dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scanner state, as the block should hold it after each accepted byte.
  logic [wbps_pkg::ADDR_W-1:0]       m_base      = '0;
  logic [63:0]                       m_pat_low   = '0;
  logic [63:0]                       m_pat_high  = '0;
  logic [wbps_pkg::WILDCARD_W-1:0]   m_wild      = '0;
  logic [wbps_pkg::LENGTH_W-1:0]     m_len_field = 5'd1;
  logic [wbps_pkg::BYTE_W-1:0]       recent_bytes [wbps_pkg::PATTERN_MAX] = '{default: '0};
  logic [wbps_pkg::OFFSET_WIDTH-1:0] byte_count = '0;

  scan_result_t expected_results[$];
  plan_row_t    directed_plan[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  reg_writes = 0;
  int  matches_seen = 0;
  int  scans_ended = 0;
  int  results_checked = 0;
  int  holds_done = 0;
  int  cycle_count = 0;
  int  calm_from = 0;
  bit  calm = 1'b0;
  bit  hold_request = 1'b0;

  // The register clamps the length: zero counts as one, and anything above
  // the window depth counts as the full window.
  function automatic int unsigned active_length();
    int unsigned len;
    len = m_len_field;
    if (len == 0)
      len = 1;
    if (len > wbps_pkg::PATTERN_MAX)
      len = wbps_pkg::PATTERN_MAX;
    return len;
  endfunction

  function automatic logic [wbps_pkg::BYTE_W-1:0] pattern_at(int unsigned k);
    if (k < 8)
      return m_pat_low[8*k +: 8];
    return m_pat_high[8*(k-8) +: 8];
  endfunction

  // Advances the model by one byte. It returns whether the byte causes a
  // result transaction, and fills in that result.
  function automatic bit scan_step(input logic [wbps_pkg::BYTE_W-1:0] d, input logic l,
                                   output scan_result_t r);
    int unsigned len;
    bit hit;
    len = active_length();
    hit = 1'b0;
    r = '0;
    for (int i = wbps_pkg::PATTERN_MAX - 1; i > 0; i--)
      recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = d;
    if (byte_count != '1)
      byte_count++;
    // A zero base switches matching off, and so does a window that is not
    // yet full. The oldest byte of the window lines up with pattern byte 0.
    if (m_base != '0 && byte_count >= len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++)
        if (!m_wild[k] && recent_bytes[len-1-k] != pattern_at(k))
          hit = 1'b0;
      if (hit)
        r.addr = m_base + wbps_pkg::ADDR_W'(byte_count - len);
    end
    r.found = hit;
    r.eos = l;
    // The last byte of an image starts the next image from a clean window.
    if (l) begin
      recent_bytes = '{default: '0};
      byte_count = '0;
    end
    return hit || l;
  endfunction

  function automatic plan_row_t write_row(logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                                          logic [wbps_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '{kind: ROW_WRITE, index: idx, value: val, default: '0};
    return r;
  endfunction

  function automatic plan_row_t byte_row(logic [wbps_pkg::BYTE_W-1:0] d, logic l);
    plan_row_t r;
    r = '{kind: ROW_BYTE, data: d, last: l, default: '0};
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [wbps_pkg::BYTE_W-1:0] d, logic l,
                                          bit has, logic found,
                                          logic [wbps_pkg::ADDR_W-1:0] addr,
                                          logic eos);
    plan_row_t r;
    r = byte_row(d, l);
    r.known = 1'b1;
    r.known_has = has;
    r.known_res = '{found: found, addr: addr, eos: eos};
    return r;
  endfunction

  // Appends one row to the directed plan.
  function automatic void add_row(plan_row_t r);
    directed_plan = {directed_plan, r};
  endfunction

  // Every driving task starts and ends just after a falling edge. A register
  // write raises the enable for one cycle and then lowers it again, so
  // back-to-back writes never assign the enable twice in one time step.
  task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [wbps_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
    case (idx)
      wbps_pkg::REG_BASE_ADDRESS:  m_base      = val;
      wbps_pkg::REG_PATTERN_LOW:   m_pat_low   = val;
      wbps_pkg::REG_PATTERN_HIGH:  m_pat_high  = val;
      wbps_pkg::REG_WILDCARD_MASK: m_wild      = val[wbps_pkg::WILDCARD_W-1:0];
      wbps_pkg::REG_PATTERN_LEN:   m_len_field = val[wbps_pkg::LENGTH_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one byte and holds it until it is taken. The expected result is
  // queued only once the transaction has been accepted.
  task automatic send_byte(input logic [wbps_pkg::BYTE_W-1:0] d, input logic l,
                           input bit known = 1'b0, input bit known_has = 1'b0,
                           input scan_result_t known_res = '0);
    scan_result_t predicted;
    bit has;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    forever begin
      @(posedge clk);
      if (in_ch.ready)
        break;
    end
    has = scan_step(d, l, predicted);
    if (known) begin
      has = known_has;
      predicted = known_res;
    end
    if (has)
      expected_results = {expected_results, predicted};
    bytes_sent++;
    @(negedge clk);
  endtask

  // Brings the block to rest before new settings go in. A byte that causes
  // no result may still be in the pipeline when the queue drains, so a few
  // more cycles are allowed on top.
  task automatic settle_input();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One random phase: fresh settings, then one to three images.
  task automatic run_scan_phase(input int phase_no);
    logic [wbps_pkg::BYTE_W-1:0] image[$];
    logic [wbps_pkg::ADDR_W-1:0] base;
    int images;
    int img_len;
    int len;
    int pos;
    bit open_end;

    settle_input();
    if (phase_no == HOLD_PHASE) begin
      // Every byte matches here, so every byte makes a result. The receiver
      // then stops taking results while the sender keeps going.
      write_reg(wbps_pkg::REG_BASE_ADDRESS, {$urandom, $urandom} | 64'd1);
      write_reg(wbps_pkg::REG_WILDCARD_MASK, '1);
      write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd1);
      hold_request = 1'b1;
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       base = '0;
          1:       base = '1;
          2:       base = 64'd1;
          default: base = {$urandom, $urandom};
        endcase
        write_reg(wbps_pkg::REG_BASE_ADDRESS, base);
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(wbps_pkg::REG_PATTERN_LOW,
                  ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom});
      if ($urandom_range(0, 3) != 0)
        write_reg(wbps_pkg::REG_PATTERN_HIGH,
                  ($urandom_range(0, 7) == 0) ? '0 : {$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(wbps_pkg::REG_WILDCARD_MASK, '0);
          1:       write_reg(wbps_pkg::REG_WILDCARD_MASK, '1);
          2:       write_reg(wbps_pkg::REG_WILDCARD_MASK, 64'($urandom & $urandom));
          default: write_reg(wbps_pkg::REG_WILDCARD_MASK, {$urandom, $urandom});
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(wbps_pkg::REG_PATTERN_LEN, '0);
          1:       write_reg(wbps_pkg::REG_PATTERN_LEN, 64'(wbps_pkg::PATTERN_MAX));
          2:       write_reg(wbps_pkg::REG_PATTERN_LEN, 64'(wbps_pkg::PATTERN_MAX + 1));
          3:       write_reg(wbps_pkg::REG_PATTERN_LEN, '1);
          4, 5:    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'($urandom_range(1, 3)));
          default: write_reg(wbps_pkg::REG_PATTERN_LEN,
                             64'($urandom_range(1, wbps_pkg::PATTERN_MAX)));
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(wbps_pkg::CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  {$urandom, $urandom});
    end

    images = $urandom_range(1, 3);
    for (int n = 0; n < images; n++) begin
      if (phase_no == HOLD_PHASE)
        img_len = $urandom_range(60, 120);
      else if ($urandom_range(0, 9) == 0)
        img_len = $urandom_range(60, 200);
      else
        img_len = $urandom_range(1, 40);
      image.delete();
      while (image.size() < img_len) begin
        if ($urandom_range(0, 2) == 0) begin
          // A planted copy of the pattern. Wildcard positions get random
          // bytes, and now and then one bit is flipped to break the copy.
          len = active_length();
          for (int k = 0; k < len; k++)
            image = {image, m_wild[k] ? wbps_pkg::BYTE_W'($urandom) : pattern_at(k)};
          if ($urandom_range(0, 5) == 0) begin
            pos = image.size() - 1 - $urandom_range(0, len - 1);
            image[pos] = image[pos] ^ wbps_pkg::BYTE_W'(1 << $urandom_range(0, 7));
          end
        end else begin
          image = {image, $urandom_range(0, 1) ? pattern_at($urandom_range(0, 15))
                                                : wbps_pkg::BYTE_W'($urandom)};
        end
      end
      // Occasionally an image runs on into the next phase's settings.
      open_end = (n == images - 1) && ($urandom_range(0, 5) == 0);
      for (int k = 0; k < img_len; k++) begin
        calm = (bytes_sent >= calm_from);
        send_byte(image[k], (k == img_len - 1) && !open_end);
      end
    end
  endtask

  // The receiver alternates between stretches of readiness and short
  // stalls. On request it holds off for a long, counted stretch instead.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst)
      @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, calm ? 1 : 16)) @(negedge clk);
      end
    end
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results still expected", $time,
               expected_results.size());
      $display("tb: done, errors");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got found %0b addr %h end %0b",
                 $time, out_ch.match_found, out_ch.match_address, out_ch.end_of_scan);
      end else begin
        automatic scan_result_t want = expected_results.pop_front();
        results_checked++;
        if (want.found)
          matches_seen++;
        if (want.eos)
          scans_ended++;
        if (out_ch.match_found !== want.found) begin
          errors++;
          $display("%0t: match_found: expected %0b, got %0b", $time, want.found,
                   out_ch.match_found);
        end
        if (out_ch.match_address !== want.addr) begin
          errors++;
          $display("%0t: match_address: expected %h, got %h", $time, want.addr,
                   out_ch.match_address);
        end
        if (out_ch.end_of_scan !== want.eos) begin
          errors++;
          $display("%0t: end_of_scan: expected %0b, got %0b", $time, want.eos,
                   out_ch.end_of_scan);
        end
      end
    end
  end

  initial begin
    int phase_no;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;

    // Reset settings: the base is zero, so nothing matches. The last byte
    // still reports the end of the scan.
    add_row(known_row(8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(known_row(8'hFF, 1'b1, 1'b1, 1'b0, '0, 1'b1));
    // All-ones base, pattern byte zero, length zero (taken as one). The
    // second match address wraps round to zero.
    add_row(write_row(wbps_pkg::REG_BASE_ADDRESS, '1));
    add_row(write_row(wbps_pkg::REG_PATTERN_LOW, '0));
    add_row(write_row(wbps_pkg::REG_PATTERN_HIGH, '0));
    add_row(write_row(wbps_pkg::REG_WILDCARD_MASK, '0));
    add_row(write_row(wbps_pkg::REG_PATTERN_LEN, '0));
    add_row(known_row(8'h00, 1'b0, 1'b1, 1'b1, '1, 1'b0));
    add_row(known_row(8'h00, 1'b1, 1'b1, 1'b1, '0, 1'b1));
    add_row(known_row(8'h01, 1'b1, 1'b1, 1'b0, '0, 1'b1));
    // Three-byte pattern with a wildcard in the middle.
    add_row(write_row(wbps_pkg::REG_BASE_ADDRESS, 64'd1));
    add_row(write_row(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_0055_00AA));
    add_row(write_row(wbps_pkg::REG_WILDCARD_MASK, 64'h0002));
    add_row(write_row(wbps_pkg::REG_PATTERN_LEN, 64'd3));
    add_row(byte_row(8'hAA, 1'b0));
    add_row(byte_row(8'h00, 1'b0));
    add_row(byte_row(8'h55, 1'b0));
    add_row(byte_row(8'hAA, 1'b0));
    add_row(byte_row(8'h12, 1'b0));
    add_row(byte_row(8'h55, 1'b1));
    // Writes to indexes past the register map must leave the settings alone.
    add_row(write_row(REG_SPARE_FIRST, '1));
    add_row(write_row(REG_SPARE_LAST, '1));
    add_row(byte_row(8'hAA, 1'b0));
    add_row(byte_row(8'h99, 1'b0));
    add_row(byte_row(8'h55, 1'b1));
    // Top-bit base, full wildcard: every byte matches once two have arrived.
    add_row(write_row(wbps_pkg::REG_BASE_ADDRESS, 64'h8000_0000_0000_0000));
    add_row(write_row(wbps_pkg::REG_PATTERN_HIGH, '1));
    add_row(write_row(wbps_pkg::REG_WILDCARD_MASK, '1));
    add_row(write_row(wbps_pkg::REG_PATTERN_LEN, 64'd2));
    add_row(byte_row(8'h00, 1'b0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'h7F, 1'b1));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        if (i == 0 || directed_plan[i-1].kind == ROW_BYTE)
          settle_input();
        write_reg(directed_plan[i].index, directed_plan[i].value);
      end else begin
        send_byte(directed_plan[i].data, directed_plan[i].last, directed_plan[i].known,
                  directed_plan[i].known_has, directed_plan[i].known_res);
      end
    end

    calm_from = bytes_sent + RANDOM_BYTES - CALM_BYTES;
    phase_no = 0;
    while (bytes_sent < calm_from + CALM_BYTES) begin
      run_scan_phase(phase_no);
      phase_no++;
    end

    // Drain the pipeline, then give any byte without a result time to pass.
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    $display("tb: %0d bytes over %0d random phases, %0d register writes", bytes_sent,
             phase_no, reg_writes);
    $display("tb: %0d results checked: %0d matches, %0d image ends, %0d long holds",
             results_checked, matches_seen, scans_ended, holds_done);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
